[rtl/core/pgalloc_pkg.sv]
package pgalloc_pkg;

  localparam int unsigned NUM_PAGES_DEF   = 1024;
  localparam int unsigned PAGE_SHIFT_DEF  = 12;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned REF_OUT_W = 16;
  localparam int unsigned LOWEST_W  = 10;

  localparam logic [OPCODE_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD_REF  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DROP_REF = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ     = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NO_PAGE   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_ADDR  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_STILL_REF = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;

  typedef struct packed {
    logic                cnt_we;
    logic                push;
    logic                pop;
    logic [STATUS_W-1:0] status;
  } pgalloc_ctl_t;

endpackage

[rtl/core/pgalloc_ram.sv]
module pgalloc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pgalloc_alu.sv]
module pgalloc_alu import pgalloc_pkg::*; #(
  parameter int unsigned NUM_PAGES   = NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int unsigned PW = $clog2(NUM_PAGES),
  localparam int unsigned TW = $clog2(NUM_PAGES + 1)
) (
  input  logic [OPCODE_W-1:0]    opcode_i,
  input  logic                   range_ok_i,
  input  logic                   free_ok_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic [TW-1:0]          top_i,
  input  logic [PW-1:0]          stack_page_i,
  output pgalloc_ctl_t           ctl_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic [ADDR_W-1:0]      page_address_o,
  output logic [REF_OUT_W-1:0]   ref_count_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   empty;
  logic                   full;

  assign cnt_dec = (count_i != '0) ? count_i - CountOne : '0;
  assign cnt_inc = (count_i != CountMax) ? count_i + CountOne : count_i;
  assign empty   = (top_i == '0);
  assign full    = (top_i >= TW'(NUM_PAGES));

  always_comb begin
    ctl_o          = '0;
    ctl_o.status   = STS_OK;
    count_o        = '0;
    page_address_o = '0;
    ref_count_o    = '0;
    case (opcode_i)
      OP_ALLOC: begin
        if (empty) begin
          ctl_o.status = STS_NO_PAGE;
        end else begin
          ctl_o.pop      = 1'b1;
          ctl_o.cnt_we   = 1'b1;
          count_o        = CountOne;
          page_address_o = ADDR_W'(stack_page_i) << PAGE_SHIFT;
          ref_count_o    = REF_OUT_W'(CountOne);
        end
      end
      OP_FREE: begin
        if (!free_ok_i) begin
          ctl_o.status = STS_BAD_ADDR;
        end else if (cnt_dec != '0) begin
          ctl_o.cnt_we = 1'b1;
          ctl_o.status = STS_STILL_REF;
          count_o      = cnt_dec;
          ref_count_o  = REF_OUT_W'(cnt_dec);
        end else if (full) begin
          ctl_o.cnt_we = 1'b1;
          ctl_o.status = STS_FULL;
        end else begin
          ctl_o.cnt_we = 1'b1;
          ctl_o.push   = 1'b1;
        end
      end
      OP_ADD_REF, OP_DROP_REF, OP_READ: begin
        if (!range_ok_i) begin
          ctl_o.status = STS_BAD_ADDR;
        end else begin
          ctl_o.cnt_we = (opcode_i != OP_READ);
          if (opcode_i == OP_ADD_REF) begin
            count_o = cnt_inc;
          end else if (opcode_i == OP_DROP_REF) begin
            count_o = cnt_dec;
          end else begin
            count_o = count_i;
          end
          ref_count_o = REF_OUT_W'(count_o);
        end
      end
      default: begin
        ctl_o.status = STS_OK;
      end
    endcase
  end

endmodule

[rtl/core/page_allocator_with_refcount.sv]
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  opcode_i, address_i
// out      output     out_valid_o / out_stall_i status_o, page_address_o, ref_count_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (lowest_page)
//
// Each transaction: the accepting edge reads the count and stack memories, and the
// execute state writes them back and loads the output register; no new one is taken meanwhile.
// A stalled output register holds the execute state until it drains.
// After reset a clearing pass zeroes all NUM_PAGES entries of the count memory
// (1024 by default), with in_stall_o high; cfg writes are taken at any time.
module page_allocator_with_refcount import pgalloc_pkg::*; #(
  parameter int unsigned NUM_PAGES   = NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [ADDR_W-1:0]    address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [ADDR_W-1:0]    page_address_o,
  output logic [REF_OUT_W-1:0] ref_count_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LOWEST_W-1:0]  cfg_data_i
);

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned TW = $clog2(NUM_PAGES + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [PW-1:0]          clr_idx_q, clr_idx_d;
  logic [TW-1:0]          top_q, top_d;
  logic [LOWEST_W-1:0]    lowest_page_q;

  logic [OPCODE_W-1:0]    op_q;
  logic                   range_ok_q;
  logic                   free_ok_q;
  logic [PW-1:0]          page_q;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [ADDR_W-1:0]      page_address_q;
  logic [REF_OUT_W-1:0]   ref_count_q;

  logic                   accept;
  logic                   out_free;
  logic                   exec_fire;
  logic [ADDR_W-1:0]      pg_full;
  logic                   in_range;
  logic                   aligned;

  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic [PW-1:0]          stk_rdata;
  logic                   cnt_we;
  logic [PW-1:0]          cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [TW-1:0]          top_dec;

  pgalloc_ctl_t           ctl;
  logic [COUNT_WIDTH-1:0] alu_count;
  logic [ADDR_W-1:0]      alu_page_address;
  logic [REF_OUT_W-1:0]   alu_ref_count;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec_fire  = (state_q == S_EXEC) && out_free;
  assign cfg_ready_o = 1'b1;

  assign pg_full  = address_i >> PAGE_SHIFT;
  assign in_range = (pg_full < ADDR_W'(NUM_PAGES));
  assign aligned  = (address_i[PAGE_SHIFT-1:0] == '0);
  assign top_dec  = top_q - TW'(1);

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    top_d     = top_q;
    case (state_q)
      S_CLEAR: begin
        clr_idx_d = clr_idx_q + PW'(1);
        if (clr_idx_q == PW'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (ctl.push) begin
            top_d = top_q + TW'(1);
          end else if (ctl.pop) begin
            top_d = top_dec;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_idx_q     <= '0;
      top_q         <= '0;
      lowest_page_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      top_q     <= top_d;
      if (cfg_valid_i && cfg_ready_o) begin
        lowest_page_q <= cfg_data_i;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opcode_i;
      range_ok_q <= in_range;
      free_ok_q  <= in_range && aligned && (pg_full >= ADDR_W'(lowest_page_q));
      page_q     <= pg_full[PW-1:0];
    end
    if (exec_fire) begin
      status_q       <= ctl.status;
      page_address_q <= alu_page_address;
      ref_count_q    <= alu_ref_count;
    end
  end

  pgalloc_alu #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_alu (
    .opcode_i      (op_q),
    .range_ok_i    (range_ok_q),
    .free_ok_i     (free_ok_q),
    .count_i       (cnt_rdata),
    .top_i         (top_q),
    .stack_page_i  (stk_rdata),
    .ctl_o         (ctl),
    .count_o       (alu_count),
    .page_address_o(alu_page_address),
    .ref_count_o   (alu_ref_count)
  );

  always_comb begin
    if (state_q == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx_q;
      cnt_wdata = '0;
    end else begin
      cnt_we    = exec_fire && ctl.cnt_we;
      cnt_waddr = ctl.pop ? stk_rdata : page_q;
      cnt_wdata = alu_count;
    end
  end

  pgalloc_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_PAGES)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (accept),
    .raddr_i(pg_full[PW-1:0]),
    .rdata_o(cnt_rdata)
  );

  pgalloc_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_PAGES)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (exec_fire && ctl.push),
    .waddr_i(top_q[PW-1:0]),
    .wdata_i(page_q),
    .re_i   (accept),
    .raddr_i(top_dec[PW-1:0]),
    .rdata_o(stk_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign page_address_o = page_address_q;
  assign ref_count_o    = ref_count_q;

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TW'(NUM_PAGES))
    else $error("free store count beyond depth");

  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !(ctl.push && ctl.pop))
    else $error("push and pop together");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && ctl.pop) |-> (top_q != '0))
    else $error("pop from empty free store");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC) && $stable(top_q))
    else $error("accepted transaction not executed");

  a_clear_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !$rose(out_valid_q))
    else $error("result during clearing pass");
`endif

endmodule

[bench/tb_page_allocator_with_refcount.sv]
module tb_page_allocator_with_refcount;
  timeunit 1ns;
  timeprecision 1ps;
  import pgalloc_pkg::*;

  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES_DEF);
  localparam int unsigned COUNT_MAX  = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int unsigned OFFSET_MAX = (1 << PAGE_SHIFT_DEF) - 1;
  localparam logic [OPCODE_W-1:0] OP_LAST = '1;
  localparam int unsigned SEG_ITEMS  = 280;
  localparam int unsigned LONG_HOLD  = 200;
  localparam int unsigned BURST_ADDS = 64;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;
  } page_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    page_address;
    logic [REF_OUT_W-1:0] ref_count;
  } page_resp_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [OPCODE_W-1:0]  opcode_i    = '0;
  logic [ADDR_W-1:0]    address_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [LOWEST_W-1:0]  cfg_data_i  = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [STATUS_W-1:0]  status_o;
  logic [ADDR_W-1:0]    page_address_o;
  logic [REF_OUT_W-1:0] ref_count_o;
  logic                 cfg_ready_o;

  page_allocator_with_refcount u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .page_address_o(page_address_o),
    .ref_count_o   (ref_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // allocator mirror
  logic [PAGE_W-1:0]          free_pages [NUM_PAGES_DEF];
  logic [COUNT_WIDTH_DEF-1:0] page_refs  [NUM_PAGES_DEF];
  int unsigned                free_depth;
  logic [LOWEST_W-1:0]        lowest_page;
  logic [PAGE_W-1:0]          held_pages [$];

  page_req_t  pending  [$];
  page_resp_t expected [$];
  page_req_t  nxt_req;
  page_resp_t want;

  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned mismatches = 0;

  bit          no_idle         = 1'b0;
  bit          long_hold_req   = 1'b0;
  bit          long_hold_taken = 1'b0;
  int unsigned hold_left       = 0;
  int unsigned send_gap        = 0;
  int unsigned stall_gap       = 0;
  bit          send_calm       = 1'b0;
  bit          recv_calm       = 1'b0;

  task automatic alloc_predict(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr);
    page_resp_t        r;
    logic [ADDR_W-1:0] pnum;
    logic [PAGE_W-1:0] pg;
    logic              in_range;
    r        = '0;
    pnum     = addr >> PAGE_SHIFT_DEF;
    in_range = pnum < NUM_PAGES_DEF;
    pg       = pnum[PAGE_W-1:0];
    case (op)
      OP_ALLOC: begin
        if (free_depth == 0) begin
          r.status = STS_NO_PAGE;
        end else begin
          free_depth     = free_depth - 1;
          pg             = free_pages[PAGE_W'(free_depth)];
          page_refs[pg]  = 1;
          r.page_address = ADDR_W'(pg) << PAGE_SHIFT_DEF;
          r.ref_count    = 1;
          held_pages.push_back(pg);
        end
      end
      OP_FREE: begin
        if (addr[PAGE_SHIFT_DEF-1:0] != '0 || !in_range || pg < lowest_page) begin
          r.status = STS_BAD_ADDR;
        end else begin
          if (page_refs[pg] != 0) page_refs[pg] = page_refs[pg] - 1'b1;
          if (page_refs[pg] != 0) begin
            r.status    = STS_STILL_REF;
            r.ref_count = REF_OUT_W'(page_refs[pg]);
          end else if (free_depth >= NUM_PAGES_DEF) begin
            r.status = STS_FULL;
          end else begin
            free_pages[PAGE_W'(free_depth)] = pg;
            free_depth                      = free_depth + 1;
          end
        end
      end
      OP_ADD_REF, OP_DROP_REF, OP_READ: begin
        if (!in_range) begin
          r.status = STS_BAD_ADDR;
        end else begin
          if (op == OP_ADD_REF && page_refs[pg] != COUNT_MAX)
            page_refs[pg] = page_refs[pg] + 1'b1;
          else if (op == OP_DROP_REF && page_refs[pg] != 0)
            page_refs[pg] = page_refs[pg] - 1'b1;
          r.ref_count = REF_OUT_W'(page_refs[pg]);
        end
      end
      default: ;
    endcase
    expected.push_back(r);
  endtask

  task automatic send(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr);
    page_req_t r;
    r.opcode  = op;
    r.address = addr;
    pending.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || expected.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_lowest(input logic [LOWEST_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lowest_page = v;
  endtask

  // mostly ops on pages that are actually held, some noise
  task automatic random_item(output page_req_t r);
    int unsigned       sel;
    int unsigned       idx;
    logic [PAGE_W-1:0] pg;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      r.opcode  = OPCODE_W'($urandom_range(OP_READ + 1, OP_LAST));
      r.address = $urandom;
    end else if (sel < 10) begin
      r.opcode  = OPCODE_W'($urandom_range(OP_ALLOC, OP_READ));
      r.address = $urandom;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 30)      r.opcode = OP_ALLOC;
      else if (sel < 60) r.opcode = OP_FREE;
      else if (sel < 75) r.opcode = OP_ADD_REF;
      else if (sel < 88) r.opcode = OP_DROP_REF;
      else               r.opcode = OP_READ;
      pg = PAGE_W'($urandom_range(0, NUM_PAGES_DEF - 1));
      if (held_pages.size() != 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, held_pages.size() - 1);
        if (page_refs[held_pages[idx]] == 0) held_pages.delete(idx);
        else pg = held_pages[idx];
      end
      r.address = ADDR_W'(pg) << PAGE_SHIFT_DEF;
      if (r.opcode == OP_ALLOC) begin
        r.address = $urandom;
      end else if (r.opcode == OP_FREE && $urandom_range(0, 19) == 0) begin
        r.address[PAGE_SHIFT_DEF-1:0] = PAGE_SHIFT_DEF'($urandom_range(1, OFFSET_MAX));
      end
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        alloc_predict(opcode_i, address_i);
        n_sent = n_sent + 1;
      end
      if ($urandom_range(0, 63) == 0) send_calm <= !send_calm;
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!no_idle && !send_calm && $urandom_range(0, 4) == 0) begin
          send_gap   <= $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0) begin
          nxt_req = pending.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= nxt_req.opcode;
          address_i  <= nxt_req.address;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: unexpected transaction status=%0d page_address=%h ref_count=%0d",
                 $time, status_o, page_address_o, ref_count_o);
      end else begin
        want = expected.pop_front();
        n_checked = n_checked + 1;
        if (status_o !== want.status || page_address_o !== want.page_address ||
            ref_count_o !== want.ref_count) begin
          mismatches = mismatches + 1;
          $display("%0t: expected status=%0d page_address=%h ref_count=%0d, %s%0d %s%h %s%0d",
                   $time, want.status, want.page_address, want.ref_count,
                   "actual status=", status_o, "page_address=", page_address_o,
                   "ref_count=", ref_count_o);
        end
      end
    end
    if ($urandom_range(0, 63) == 0) recv_calm <= !recv_calm;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left       <= LONG_HOLD - 1;
      out_stall_i     <= 1'b1;
    end else if (stall_gap != 0) begin
      stall_gap   <= stall_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!no_idle && !recv_calm && $urandom_range(0, 4) == 0) begin
      stall_gap   <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    page_req_t         req;
    int unsigned       seg;
    int unsigned       i;
    logic [LOWEST_W-1:0] mid_lowest;
    logic [LOWEST_W-1:0] seg_lowest;
    logic [PAGE_W-1:0] sat_page;
    for (i = 0; i < NUM_PAGES_DEF; i++) page_refs[PAGE_W'(i)] = '0;
    free_depth  = 0;
    lowest_page = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_lowest('0);

    // directed corners
    send(OP_ALLOC,     32'h0000_0000);
    send(OP_READ,      32'h0000_0000);
    send(OP_READ,      32'hFFFF_FFFF);
    send(OP_DROP_REF,  32'h0000_0000);
    send(OP_FREE,      32'h0000_0001);
    send(OP_FREE,      32'h0040_0000);
    send(OP_ADD_REF,   32'hFFFF_F000);
    send(OP_DROP_REF,  32'hFFFF_F000);
    send(OPCODE_W'(OP_READ + 1), 32'hFFFF_FFFF);
    send(OPCODE_W'(OP_READ + 2), 32'h0000_0000);
    send(OP_LAST,      32'hFFFF_FFFF);
    send(OP_FREE,      32'h003F_F000);
    send(OP_FREE,      32'h0000_0000);
    send(OP_ALLOC,     32'hFFFF_FFFF);
    send(OP_ADD_REF,   32'h0000_0000);
    send(OP_ADD_REF,   32'h0000_0000);
    send(OP_FREE,      32'h0000_0000);
    send(OP_DROP_REF,  32'h0000_0FFF);
    send(OP_DROP_REF,  32'h0000_0000);
    send(OP_DROP_REF,  32'h0000_0000);
    send(OP_FREE,      32'h0000_0000);
    send(OP_FREE,      32'h0000_0000);
    repeat (4) send(OP_ALLOC, 32'h0000_0000);
    wait_drained();

    // fill the free store, with the output held off long enough to back up the input
    long_hold_req = 1'b1;
    for (i = 0; i < NUM_PAGES_DEF; i++) send(OP_FREE, ADDR_W'(i) << PAGE_SHIFT_DEF);
    send(OP_FREE, 32'h0000_5000);
    wait_drained();

    mid_lowest = LOWEST_W'($urandom_range(1, NUM_PAGES_DEF - 2));
    for (seg = 0; seg < 3; seg++) begin
      if (seg == 0)      seg_lowest = LOWEST_W'(NUM_PAGES_DEF - 1);
      else if (seg == 1) seg_lowest = mid_lowest;
      else               seg_lowest = '0;
      write_lowest(seg_lowest);
      for (i = 0; i < SEG_ITEMS; i++) begin
        if (seg == 1 && i == SEG_ITEMS / 2) wait_drained();
        while (pending.size() >= 3) @(posedge clk_i);
        random_item(req);
        pending.push_back(req);
      end
      wait_drained();
    end

    // back-to-back adds on one page
    no_idle  = 1'b1;
    sat_page = PAGE_W'($urandom_range(0, NUM_PAGES_DEF - 1));
    for (i = 0; i < BURST_ADDS; i++) send(OP_ADD_REF, ADDR_W'(sat_page) << PAGE_SHIFT_DEF);
    send(OP_READ,     ADDR_W'(sat_page) << PAGE_SHIFT_DEF);
    send(OP_DROP_REF, ADDR_W'(sat_page) << PAGE_SHIFT_DEF);
    send(OP_FREE,     ADDR_W'(sat_page) << PAGE_SHIFT_DEF);
    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("%0d transactions sent, %0d results checked, %0d mismatches",
             n_sent, n_checked, mismatches);
    $display("covered empty/full store, lowest_page 0/%0d/%0d, back-to-back adds on page %0d",
             NUM_PAGES_DEF - 1, mid_lowest, sat_page);
    if (mismatches == 0 && expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("%0t: timeout, %0d results still outstanding", $time, expected.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
